/* rtl/core/bprc_pkg.sv */
// shared types, codes and constants for the bus packet receiver
package bprc_pkg;

  // queue depth between the packet front and the cache back
  localparam int QUEUE_DEPTH = 4;

  // reset values of the configuration registers
  localparam logic [7:0] DOMAIN_RESET    = 8'd1;
  localparam logic [7:0] OWN_ID_RESET    = 8'h22;
  localparam logic [7:0] BCAST_RESET     = 8'd32;
  localparam logic [7:0] TIMEOUT_RESET   = 8'd3;
  localparam logic [7:0] IDLE_MAX        = 8'd255;

  // configuration register indexes
  localparam logic [1:0] CFG_DOMAIN  = 2'd0;
  localparam logic [1:0] CFG_OWN_ID  = 2'd1;
  localparam logic [1:0] CFG_BCAST   = 2'd2;
  localparam logic [1:0] CFG_TIMEOUT = 2'd3;

  // input item kinds
  localparam logic FUNC_BYTE = 1'b0;
  localparam logic FUNC_TICK = 1'b1;

  // byte phases: the phase in which each packet byte arrives
  localparam logic [2:0] PH_HUNT     = 3'd0;
  localparam logic [2:0] PH_SENDER   = 3'd1;
  localparam logic [2:0] PH_RECEIVER = 3'd2;
  localparam logic [2:0] PH_PARAM    = 3'd3;
  localparam logic [2:0] PH_VALUE    = 3'd4;
  localparam logic [2:0] PH_CHECK    = 3'd5;

  typedef enum logic [1:0] {
    ST_ACCEPT  = 2'd0,
    ST_CHKSUM  = 2'd1,
    ST_OTHER   = 2'd2,
    ST_TIMEOUT = 2'd3
  } status_t;

  typedef struct packed {
    logic [7:0] domain_code;
    logic [7:0] own_id;
    logic [7:0] broadcast_id;
    logic [7:0] byte_timeout_ticks;
  } cfg_t;

  typedef struct packed {
    logic       func;
    logic [7:0] rx_byte;
  } in_t;

  // classified packet passed from front to back
  typedef struct packed {
    status_t    status;
    logic [7:0] sender;
    logic [7:0] receiver;
    logic [7:0] param_code;
    logic [7:0] param_value;
  } req_t;

  typedef struct packed {
    status_t    status;
    logic [7:0] sender;
    logic [7:0] receiver;
    logic [7:0] param_code;
    logic [7:0] param_value;
    logic       value_changed;
  } out_t;

endpackage

/* rtl/core/bprc_front.sv */
// packet assembler: hunts for the domain byte, collects, checks and classifies packets
module bprc_front (
  input  logic            clk,
  input  logic            rst,
  input  bprc_pkg::cfg_t  cfg,
  input  logic            in_valid,
  input  logic            in_stall,
  input  bprc_pkg::in_t   in_data,
  output logic            push,
  output bprc_pkg::req_t  push_data
);

  logic [2:0] phase, phase_next;
  logic [7:0] sum, sum_next;
  logic [7:0] idle, idle_next;
  logic [7:0] sender_b, receiver_b, param_b, value_b;
  logic [7:0] idle_inc;
  logic       accept;

  assign accept   = in_valid && !in_stall;
  assign idle_inc = (idle == bprc_pkg::IDLE_MAX) ? idle : idle + 8'd1;

  // phase, checksum and idle tracking
  always_comb begin
    phase_next = phase;
    sum_next   = sum;
    idle_next  = idle;
    push       = 1'b0;
    push_data.status      = bprc_pkg::ST_ACCEPT;
    push_data.sender      = (phase > bprc_pkg::PH_SENDER)   ? sender_b   : 8'd0;
    push_data.receiver    = (phase > bprc_pkg::PH_RECEIVER) ? receiver_b : 8'd0;
    push_data.param_code  = (phase > bprc_pkg::PH_PARAM)    ? param_b    : 8'd0;
    push_data.param_value = (phase > bprc_pkg::PH_VALUE)    ? value_b    : 8'd0;
    if (accept) begin
      if (in_data.func == bprc_pkg::FUNC_TICK) begin
        if (phase != bprc_pkg::PH_HUNT) begin
          if (idle_inc >= cfg.byte_timeout_ticks) begin
            push             = 1'b1;
            push_data.status = bprc_pkg::ST_TIMEOUT;
            phase_next       = bprc_pkg::PH_HUNT;
            idle_next        = 8'd0;
            sum_next         = 8'd0;
          end else begin
            idle_next = idle_inc;
          end
        end
      end else if (phase == bprc_pkg::PH_HUNT) begin
        if (in_data.rx_byte == cfg.domain_code) begin
          sum_next   = in_data.rx_byte;
          idle_next  = 8'd0;
          phase_next = bprc_pkg::PH_SENDER;
        end
      end else if (phase != bprc_pkg::PH_CHECK) begin
        idle_next  = 8'd0;
        sum_next   = sum + in_data.rx_byte;
        phase_next = phase + 3'd1;
      end else begin
        // checksum byte ends the packet
        idle_next  = 8'd0;
        push       = 1'b1;
        phase_next = bprc_pkg::PH_HUNT;
        sum_next   = 8'd0;
        if (in_data.rx_byte != sum) begin
          push_data.status = bprc_pkg::ST_CHKSUM;
        end else if (receiver_b != cfg.own_id && receiver_b != cfg.broadcast_id) begin
          push_data.status = bprc_pkg::ST_OTHER;
        end else begin
          push_data.status = bprc_pkg::ST_ACCEPT;
        end
      end
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= bprc_pkg::PH_HUNT;
      sum   <= 8'd0;
      idle  <= 8'd0;
    end else begin
      phase <= phase_next;
      sum   <= sum_next;
      idle  <= idle_next;
    end
  end

  // packet byte capture
  always_ff @(posedge clk) begin
    if (accept && in_data.func == bprc_pkg::FUNC_BYTE) begin
      unique case (phase)
        bprc_pkg::PH_SENDER:   sender_b   <= in_data.rx_byte;
        bprc_pkg::PH_RECEIVER: receiver_b <= in_data.rx_byte;
        bprc_pkg::PH_PARAM:    param_b    <= in_data.rx_byte;
        bprc_pkg::PH_VALUE:    value_b    <= in_data.rx_byte;
        default: ;
      endcase
    end
  end

endmodule

/* rtl/core/bprc_fifo.sv */
// short request queue between the packet front and the cache back
module bprc_fifo #(
  parameter int DEPTH = bprc_pkg::QUEUE_DEPTH
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  bprc_pkg::req_t  push_data,
  input  logic            pop,
  output logic            full,
  output logic            head_valid,
  output bprc_pkg::req_t  head_data
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  bprc_pkg::req_t entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;

  assign full       = (count == CNT_W'(DEPTH));
  assign head_valid = (count != '0);
  assign head_data  = entries[rd_ptr];

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

endmodule

/* rtl/core/bprc_cache.sv */
// parameter cache: read, compare and update per accepted packet, plus output register
module bprc_cache (
  input  logic            clk,
  input  logic            rst,
  input  logic            head_valid,
  input  bprc_pkg::req_t  head_data,
  output logic            pop,
  output logic            out_valid,
  input  logic            out_stall,
  output bprc_pkg::out_t  out_data
);

  logic [7:0]     cache_value [256];
  logic [255:0]   cache_valid;
  logic [7:0]     rd_data;

  logic           s1_valid;
  bprc_pkg::req_t s1;
  logic           s1_byp;
  logic [7:0]     s1_byp_data;

  logic           s1_move;
  logic           wr_en;
  logic [7:0]     old_value;
  logic           changed;

  assign s1_move   = s1_valid && (!out_valid || !out_stall);
  assign pop       = head_valid && (!s1_valid || s1_move);
  assign wr_en     = s1_move && (s1.status == bprc_pkg::ST_ACCEPT);
  assign old_value = s1_byp ? s1_byp_data : rd_data;
  assign changed   = (s1.status == bprc_pkg::ST_ACCEPT) &&
                     (!cache_valid[s1.param_code] || old_value != s1.param_value);

  // cache memory: registered read on pop, write when an accepted packet leaves stage 1
  always_ff @(posedge clk) begin
    if (wr_en) begin
      cache_value[s1.param_code] <= s1.param_value;
    end
    if (pop) begin
      rd_data <= cache_value[head_data.param_code];
    end
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      cache_valid <= '0;
    end else if (wr_en) begin
      cache_valid[s1.param_code] <= 1'b1;
    end
  end

  // lookup stage, with bypass when the read meets a write to the same entry
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (pop) begin
      s1_valid <= 1'b1;
    end else if (s1_move) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      s1          <= head_data;
      s1_byp      <= wr_en && (s1.param_code == head_data.param_code);
      s1_byp_data <= s1.param_value;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= s1_move || (out_valid && out_stall);
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      out_data.status        <= s1.status;
      out_data.sender        <= s1.sender;
      out_data.receiver      <= s1.receiver;
      out_data.param_code    <= s1.param_code;
      out_data.param_value   <= s1.param_value;
      out_data.value_changed <= changed;
    end
  end

endmodule

/* rtl/core/bus_packet_receiver_param_cache_unit.sv */
// top level of the bus packet receiver with parameter cache
//
//   channel  | direction | handshake          | payload
//   ---------+-----------+--------------------+-------------------------------------
//   in       | input     | in_valid/in_stall  | func, rx_byte
//   out      | output    | out_valid/out_stall| status, sender, receiver, param, value,
//            |           |                    | value_changed
//   cfg      | input     | cfg_write          | cfg_index, cfg_data
//
// one item (byte or tick) is taken per cycle unless in_stall; after a checksum byte or
// timeout tick its result goes through queue, cache read stage and output register.
// back end: one request per cycle unless out_stall; one read each, a write if accepted.
// reset is synchronous; it clears phase, counters, queue and all cache valid bits.
// in_stall rises only while the request queue is full, which follows out_stall.
module bus_packet_receiver_param_cache_unit #(
  parameter int QUEUE_DEPTH = bprc_pkg::QUEUE_DEPTH
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_stall,
  input  bprc_pkg::in_t   in_data,
  output logic            out_valid,
  input  logic            out_stall,
  output bprc_pkg::out_t  out_data,
  input  logic            cfg_write,
  input  logic [1:0]      cfg_index,
  input  logic [7:0]      cfg_data
);

  bprc_pkg::cfg_t cfg;
  logic           push;
  bprc_pkg::req_t push_data;
  logic           pop;
  logic           full;
  logic           head_valid;
  bprc_pkg::req_t head_data;

  assign in_stall = full;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.domain_code        <= bprc_pkg::DOMAIN_RESET;
      cfg.own_id             <= bprc_pkg::OWN_ID_RESET;
      cfg.broadcast_id       <= bprc_pkg::BCAST_RESET;
      cfg.byte_timeout_ticks <= bprc_pkg::TIMEOUT_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        bprc_pkg::CFG_DOMAIN:  cfg.domain_code        <= cfg_data;
        bprc_pkg::CFG_OWN_ID:  cfg.own_id             <= cfg_data;
        bprc_pkg::CFG_BCAST:   cfg.broadcast_id       <= cfg_data;
        bprc_pkg::CFG_TIMEOUT: cfg.byte_timeout_ticks <= cfg_data;
      endcase
    end
  end

  bprc_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (in_valid),
    .in_stall  (full),
    .in_data   (in_data),
    .push      (push),
    .push_data (push_data)
  );

  bprc_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_data  (push_data),
    .pop        (pop),
    .full       (full),
    .head_valid (head_valid),
    .head_data  (head_data)
  );

  bprc_cache u_cache (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head_data  (head_data),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data)
  );

  // the front never writes into a full queue
  a_no_overflow: assert property (@(posedge clk) disable iff (rst) push |-> !full)
    else $error("request pushed into full queue");

  // rejected or timed-out packets never report a changed value
  a_reject_unchanged: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.status != bprc_pkg::ST_ACCEPT) |-> !out_data.value_changed)
    else $error("value_changed set on a rejected packet");

  // no result right after reset
  a_reset_quiet: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result present after reset");

endmodule

/* dv/bprc_report_checker.sv */
// packet report checker: predicts receiver reports and compares them with the output channel
module bprc_report_checker
  import bprc_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  input  logic  in_stall,
  input  in_t   in_data,
  input  logic  out_valid,
  input  logic  out_stall,
  input  out_t  out_data,
  input  logic  cfg_write,
  input  logic  [1:0] cfg_index,
  input  logic  [7:0] cfg_data,
  output int    errors,
  output int    pending
);

  // register copies
  logic [7:0] domain_r;
  logic [7:0] own_r;
  logic [7:0] bcast_r;
  logic [7:0] timeout_r;

  // receiver state
  logic [2:0] phase;
  logic [7:0] pkt_byte [5];
  logic [7:0] sum_r;
  logic [7:0] idle_r;
  bit         cache_ok [256];
  logic [7:0] cache_byte [256];

  out_t expected_reports [$];
  int   fails = 0;

  // packet byte if already received, else zero
  function automatic logic [7:0] held(int idx);
    return (phase > idx) ? pkt_byte[idx] : 8'd0;
  endfunction

  function automatic out_t make_report(status_t st, logic chg);
    out_t r;
    r.status        = st;
    r.sender        = held(1);
    r.receiver      = held(2);
    r.param_code    = held(3);
    r.param_value   = held(4);
    r.value_changed = chg;
    return r;
  endfunction

  // advance the receiver by one request, queue a report if one is due
  task automatic receive_item(input in_t item);
    logic [7:0] b;
    logic [7:0] prm;
    logic [7:0] val;
    logic       chg;
    b = item.rx_byte;
    if (item.func == FUNC_TICK) begin
      if (phase == PH_HUNT) return;
      if (idle_r != IDLE_MAX) idle_r++;
      // a zero timeout fires on the first tick, same as one
      if (idle_r >= timeout_r) begin
        expected_reports.push_back(make_report(ST_TIMEOUT, 1'b0));
        phase  = PH_HUNT;
        idle_r = '0;
        sum_r  = '0;
      end
      return;
    end
    // hunting: only the domain byte opens a packet
    if (phase == PH_HUNT) begin
      if (b == domain_r) begin
        pkt_byte[0] = b;
        sum_r       = b;
        idle_r      = '0;
        phase       = PH_SENDER;
      end
      return;
    end
    idle_r = '0;
    if (phase != PH_CHECK) begin
      pkt_byte[phase] = b;
      sum_r           = sum_r + b;
      phase           = phase + 3'd1;
      return;
    end
    // checksum byte closes the packet
    if (b != sum_r) begin
      expected_reports.push_back(make_report(ST_CHKSUM, 1'b0));
    end else if (pkt_byte[2] != own_r && pkt_byte[2] != bcast_r) begin
      expected_reports.push_back(make_report(ST_OTHER, 1'b0));
    end else begin
      prm = pkt_byte[3];
      val = pkt_byte[4];
      chg = !cache_ok[prm] || cache_byte[prm] != val;
      expected_reports.push_back(make_report(ST_ACCEPT, chg));
      cache_ok[prm]   = 1'b1;
      cache_byte[prm] = val;
    end
    phase = PH_HUNT;
    sum_r = '0;
  endtask

  function automatic int field_diff(string name, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
      return 1;
    end
    return 0;
  endfunction

  always @(posedge clk) begin
    out_t want;
    if (rst) begin
      domain_r  = DOMAIN_RESET;
      own_r     = OWN_ID_RESET;
      bcast_r   = BCAST_RESET;
      timeout_r = TIMEOUT_RESET;
      phase     = PH_HUNT;
      sum_r     = '0;
      idle_r    = '0;
      foreach (cache_ok[i]) cache_ok[i] = 1'b0;
      expected_reports.delete();
    end else begin
      // register writes
      if (cfg_write) begin
        case (cfg_index)
          CFG_DOMAIN:  domain_r  = cfg_data;
          CFG_OWN_ID:  own_r     = cfg_data;
          CFG_BCAST:   bcast_r   = cfg_data;
          CFG_TIMEOUT: timeout_r = cfg_data;
          default: ;
        endcase
      end
      // compare reports leaving the block
      if (out_valid && !out_stall) begin
        if (expected_reports.size() == 0) begin
          $display("%0t: report with none expected, expected nothing, got %h",
                   $time, out_data);
          fails++;
        end else begin
          want = expected_reports.pop_front();
          fails += field_diff("status", {6'd0, want.status}, {6'd0, out_data.status});
          fails += field_diff("sender", want.sender, out_data.sender);
          fails += field_diff("receiver", want.receiver, out_data.receiver);
          fails += field_diff("param_code", want.param_code, out_data.param_code);
          fails += field_diff("param_value", want.param_value, out_data.param_value);
          fails += field_diff("value_changed", {7'd0, want.value_changed},
                              {7'd0, out_data.value_changed});
        end
      end
      // requests entering the block
      if (in_valid && !in_stall) receive_item(in_data);
    end
    errors  <= fails;
    pending <= expected_reports.size();
  end

endmodule

/* dv/tb_bus_packet_receiver_param_cache_unit.sv */
// testbench top: stimulus, flow control and verdict for the bus packet receiver
module tb_bus_packet_receiver_param_cache_unit;
  import bprc_pkg::*;

  localparam int CYCLE_LIMIT = 1000000;
  localparam int HOLD_CYCLES = 300;

  logic       clk       = 1'b0;
  logic       rst       = 1'b1;
  logic       in_valid  = 1'b0;
  logic       in_stall;
  in_t        in_data   = '0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  out_t       out_data;
  logic       cfg_write = 1'b0;
  logic [1:0] cfg_index = CFG_DOMAIN;
  logic [7:0] cfg_data  = '0;

  int errors;
  int pending;
  int sent        = 0;
  int cycle_count = 0;
  bit steady      = 1'b0;
  bit hold_off    = 1'b0;

  // current register settings, used to shape packets
  logic [7:0] cur_domain = DOMAIN_RESET;
  logic [7:0] cur_own    = OWN_ID_RESET;
  logic [7:0] cur_bcast  = BCAST_RESET;
  logic [7:0] cur_tmo    = TIMEOUT_RESET;

  bus_packet_receiver_param_cache_unit DUT (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  bprc_report_checker checker_i (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .errors    (errors),
    .pending   (pending)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // mostly short gaps, a few long ones
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic int eff_timeout();
    return (cur_tmo == 8'd0) ? 1 : int'(cur_tmo);
  endfunction

  // output side flow control, with one long hold-off when requested
  initial begin
    int stall_left;
    int hold_left;
    bit hold_used;
    stall_left = 0;
    hold_left  = 0;
    hold_used  = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off && !hold_used) begin
        hold_used = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else if (steady) begin
        out_stall <= 1'b0;
      end else if (stall_left > 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else begin
        out_stall <= 1'b0;
        if ($urandom_range(0, 3) == 0) stall_left = gap_len();
      end
    end
  end

  // offer one request and wait until it is taken
  task automatic send_item(input logic f, input logic [7:0] b);
    int g;
    g = steady ? 0 : gap_len();
    repeat (g) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_data  <= '{func: f, rx_byte: b};
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent++;
  endtask

  // ticks that stay below the timeout
  task automatic short_ticks();
    int tm;
    int n;
    tm = eff_timeout();
    if (tm < 2) return;
    n = ($urandom_range(0, 15) == 0) ? tm - 1 : $urandom_range(1, (tm - 1 < 4) ? tm - 1 : 4);
    repeat (n) send_item(FUNC_TICK, 8'($urandom_range(0, 255)));
  endtask

  // one packet, optionally with a bad checksum or cut short and left to time out
  task automatic send_packet(input logic [7:0] snd, input logic [7:0] rcv,
                             input logic [7:0] prm, input logic [7:0] val,
                             input bit bad_sum, input int keep);
    logic [7:0] pkt [6];
    int i;
    pkt[0] = cur_domain;
    pkt[1] = snd;
    pkt[2] = rcv;
    pkt[3] = prm;
    pkt[4] = val;
    pkt[5] = pkt[0] + pkt[1] + pkt[2] + pkt[3] + pkt[4];
    if (bad_sum) pkt[5] = pkt[5] + 8'($urandom_range(1, 255));
    for (i = 0; i < keep; i++) begin
      if (i > 0 && $urandom_range(0, 7) == 0) short_ticks();
      send_item(FUNC_BYTE, pkt[i]);
    end
    if (keep < 6) begin
      repeat (eff_timeout()) send_item(FUNC_TICK, 8'($urandom_range(0, 255)));
    end
  endtask

  // mostly well-formed packets, some noise, bad sums and cut packets
  task automatic random_traffic(input int n);
    int stop;
    int r;
    int k;
    logic [7:0] rcv;
    logic [7:0] prm;
    logic [7:0] val;
    stop = sent + n;
    while (sent < stop) begin
      r = $urandom_range(0, 99);
      if (r < 12) begin
        send_item(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
      end else begin
        k   = $urandom_range(0, 9);
        rcv = (k < 4) ? cur_own : (k < 7) ? cur_bcast : 8'($urandom_range(0, 255));
        prm = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
                                          : 8'($urandom_range(0, 7));
        val = ($urandom_range(0, 1) == 0) ? 8'($urandom_range(0, 3))
                                          : 8'($urandom_range(0, 255));
        send_packet(8'($urandom_range(0, 255)), rcv, prm, val, r < 22,
                    (r >= 22 && r < 32) ? $urandom_range(1, 5) : 6);
      end
    end
  endtask

  // write all registers once the block has drained
  task automatic set_config(input logic [7:0] dom, input logic [7:0] own,
                            input logic [7:0] bcast, input logic [7:0] tmo);
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= CFG_DOMAIN;
    cfg_data  <= dom;
    @(negedge clk);
    cfg_index <= CFG_OWN_ID;
    cfg_data  <= own;
    @(negedge clk);
    cfg_index <= CFG_BCAST;
    cfg_data  <= bcast;
    @(negedge clk);
    cfg_index <= CFG_TIMEOUT;
    cfg_data  <= tmo;
    @(negedge clk);
    cfg_write <= 1'b0;
    cur_domain = dom;
    cur_own    = own;
    cur_bcast  = bcast;
    cur_tmo    = tmo;
  endtask

  // main sequence
  initial begin
    repeat (8) @(negedge clk);
    rst <= 1'b0;

    // directed: ticks and noise while hunting
    send_item(FUNC_TICK, 8'hFF);
    send_item(FUNC_BYTE, 8'h00);
    send_item(FUNC_BYTE, 8'hFF);
    // accepted with an empty cache entry, then the same value again
    send_packet(8'h00, OWN_ID_RESET, 8'hFF, 8'h00, 1'b0, 6);
    send_packet(8'hFF, OWN_ID_RESET, 8'hFF, 8'h00, 1'b0, 6);
    // other receiver, domain byte reused inside the packet
    send_packet(DOMAIN_RESET, 8'h55, 8'h00, DOMAIN_RESET, 1'b0, 6);
    // checksum error, then a good broadcast packet
    send_packet(8'h12, BCAST_RESET, 8'h00, 8'hFF, 1'b1, 6);
    send_packet(8'h34, BCAST_RESET, 8'h00, 8'h7F, 1'b0, 6);
    // partial packet left to time out
    send_packet(8'h56, OWN_ID_RESET, 8'h01, 8'h02, 1'b0, 2);

    // random phases over several register settings
    set_config(8'h00, 8'h00, 8'hFF, 8'h00);
    random_traffic(400);
    set_config(8'hFF, 8'hFF, 8'h00, 8'hFF);
    random_traffic(300);
    // back-to-back with a long output hold-off
    set_config(8'hA5, 8'h5A, 8'h22, 8'h01);
    steady   = 1'b1;
    hold_off = 1'b1;
    random_traffic(400);
    steady = 1'b0;
    set_config(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
               8'($urandom_range(0, 255)), 8'($urandom_range(1, 12)));
    random_traffic(400);
    set_config(DOMAIN_RESET, OWN_ID_RESET, BCAST_RESET, TIMEOUT_RESET);
    random_traffic(400);

    // drain and decide
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/core/bprc_pkg.sv
rtl/core/bprc_front.sv
rtl/core/bprc_fifo.sv
rtl/core/bprc_cache.sv
rtl/core/bus_packet_receiver_param_cache_unit.sv
dv/bprc_report_checker.sv
dv/tb_bus_packet_receiver_param_cache_unit.sv
